// ===== rtl/sieve_divisor_count_macros.svh =====
// Assertion macros for the sieve divisor count block.
// Included by the port checker; no other dependencies.
`ifndef SIEVE_DIVISOR_COUNT_MACROS_SVH
`define SIEVE_DIVISOR_COUNT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SDC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define SDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/sdc_pkg.sv =====
// Package for the sieve divisor count block: sizes, payload types, status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sdc_pkg;
  localparam int unsigned LimitMaxDefault   = 16384;
  localparam int unsigned PrimeSlotsDefault = 2048;
  localparam logic [14:0] LimitReset = 15'd13000;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StZero     = 2'd1;
  localparam logic [1:0] StRange    = 2'd2;
  localparam logic [1:0] StNotBuilt = 2'd3;

  localparam logic ReqBuild = 1'b0;
  localparam logic ReqQuery = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [13:0] query_value;
  } req_t;

  typedef struct packed {
    logic [7:0]  divisor_count;
    logic [11:0] prime_count;
    logic [1:0]  status;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic start_build;   // load limit, zero counters
    logic clr_step;      // clear one bit-table word
    logic sieve_init;    // i = 3
    logic sieve_chk;     // read mark of i
    logic mark_init;     // j = i*i
    logic mark_step;     // read-modify-write bit j
    logic sieve_next;    // i += 2
    logic rec_init;      // record 2, i = 3
    logic rec_step;      // look at i, record if prime
    logic build_done;
    logic q_init;        // k = 0, n loaded
    logic q_fetch;       // read prime k
    logic div_start;     // start division n / p
    logic div_step;
    logic div_take;      // consume division result
    logic q_next;        // fold exponent, k++
    logic rsp_load;      // load output register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clr_last;
    logic sieve_over;    // i*i > lim
    logic i_marked;
    logic mark_over;     // j > lim or j >= LimitMax
    logic rec_over;      // i >= lim
    logic q_over;        // k >= total or p > n or p < 2
    logic div_done;
    logic div_exact;     // remainder zero
    logic built;
  } sts_t;
endpackage
`default_nettype wire

// ===== rtl/sdc_datapath.sv =====
// Datapath: bit table and prime table memories, sieve counters, serial divider.
// Depends on sdc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdc_datapath #(
  parameter int unsigned LimitMax   = sdc_pkg::LimitMaxDefault,
  parameter int unsigned PrimeSlots = sdc_pkg::PrimeSlotsDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire sdc_pkg::cmd_t cmd_i,
  output sdc_pkg::sts_t      sts_o,
  input  wire logic [14:0]   limit_i,
  input  wire sdc_pkg::req_t req_i,
  output sdc_pkg::rsp_t      rsp_o
);
  localparam int unsigned Words = (LimitMax + 31) / 32;
  localparam int unsigned WW = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned LW = $clog2(LimitMax + 1);
  localparam int unsigned SW = $clog2(PrimeSlots);
  localparam int unsigned CW = $clog2(PrimeSlots + 1);

  // Memories.
  logic [31:0]  bits_mem [Words];
  logic [13:0]  prime_mem [PrimeSlots];
  logic [31:0]  bits_rd_q;
  logic [13:0]  prime_rd_q;

  logic [LW-1:0] lim_q, blim_q;
  logic [LW-1:0] i_q, i_d, j_q, j_d;
  logic [WW-1:0] clr_q;
  logic [CW-1:0] total_q, total_d, k_q;
  logic          built_q;
  logic [13:0]   n_q, p_q, quo_q, rem_q;
  logic [3:0]    dcnt_q;
  logic [7:0]    exp_q, res_q;
  logic [15:0]   prod;

  logic [LW-1:0] lim_sat;
  logic [2*LW-1:0] ii;
  logic [LW-1:0] addr;
  logic [4:0]    bitsel_q;
  logic          rec_wr;
  sdc_pkg::rsp_t rsp_d;

  always_comb begin
    if (limit_i < 15'd3) lim_sat = LW'(3);
    else if ({17'd0, limit_i} > 32'(LimitMax)) lim_sat = LW'(LimitMax);
    else lim_sat = LW'(limit_i);
  end

  assign ii   = i_q * i_q;
  // Address used for table reads: j while marking, else i.
  assign addr = (cmd_i.mark_step || cmd_i.mark_init) ? j_q : i_q;

  // Bit table: clear sweep, mark read-modify-write, plain read.
  // Marking reads then writes each bit: mark_init/previous step reads, step writes.
  logic       rmw_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      bits_mem[clr_q] <= '0;
    end else if (cmd_i.mark_step && rmw_q) begin
      bits_mem[j_q[WW+4:5]] <= bits_rd_q | (32'd1 << bitsel_q);
    end
    bits_rd_q <= bits_mem[addr[WW+4:5]];
    bitsel_q  <= addr[4:0];
  end

  assign rec_wr = cmd_i.rec_init ||
                  (cmd_i.rec_step && rmw_q && !bits_rd_q[bitsel_q] && (i_q < lim_q));
  always_ff @(posedge clk_i) begin
    if (rec_wr && total_q < CW'(PrimeSlots)) begin
      prime_mem[total_q[SW-1:0]] <= cmd_i.rec_init ? 14'd2 : 14'(i_q);
    end
    prime_rd_q <= prime_mem[k_q[SW-1:0]];
  end

  always_comb begin
    total_d = total_q;
    if (rec_wr && total_q < CW'(PrimeSlots)) total_d = total_q + 1'b1;
  end

  always_comb begin
    i_d = i_q;
    j_d = j_q;
    if (cmd_i.sieve_init || cmd_i.rec_init) i_d = LW'(3);
    if (cmd_i.sieve_next) i_d = i_q + LW'(2);
    if (cmd_i.rec_step && rmw_q) i_d = i_q + LW'(2);
    if (cmd_i.mark_init) j_d = LW'(ii);
    if (cmd_i.mark_step && rmw_q) j_d = j_q + {i_q[LW-2:0], 1'b0};
  end

  // rmw_q marks the use step of a read/use pair, after its read step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmw_q   <= 1'b0;
      total_q <= '0;
      built_q <= 1'b0;
      blim_q  <= '0;
      clr_q   <= '0;
    end else begin
      rmw_q   <= (cmd_i.mark_step || cmd_i.rec_step) ? !rmw_q : 1'b0;
      total_q <= cmd_i.start_build ? '0 : total_d;
      clr_q   <= cmd_i.start_build ? '0 : (cmd_i.clr_step ? clr_q + 1'b1 : clr_q);
      if (cmd_i.build_done) begin
        built_q <= 1'b1;
        blim_q  <= lim_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_build) lim_q <= lim_sat;
    i_q <= i_d;
    j_q <= j_d;
  end

  // Query: prime walk and shift-subtract divider, one quotient bit a cycle.
  logic [14:0] trial;
  assign trial = {rem_q, quo_q[13]} - {1'b0, p_q};
  assign prod  = exp_q * res_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.q_init) begin
      n_q   <= req_i.query_value;
      k_q   <= '0;
      res_q <= 8'd1;
    end
    if (cmd_i.q_fetch) begin
      p_q   <= prime_rd_q;
      exp_q <= 8'd1;
    end
    if (cmd_i.div_start) begin
      quo_q  <= n_q;
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + 1'b1;
      if (!trial[14]) begin
        rem_q <= trial[13:0];
        quo_q <= {quo_q[12:0], 1'b1};
      end else begin
        rem_q <= {rem_q[12:0], quo_q[13]};
        quo_q <= {quo_q[12:0], 1'b0};
      end
    end
    if (cmd_i.div_take) begin
      n_q   <= quo_q;
      exp_q <= exp_q + 1'b1;
    end
    if (cmd_i.q_next) begin
      res_q <= prod[7:0];
      k_q   <= k_q + 1'b1;
    end
  end

  // Response value, checks in order: build, not built, zero, out of range.
  always_comb begin
    rsp_d = '0;
    if (req_i.req_type == sdc_pkg::ReqBuild) begin
      rsp_d.prime_count = 12'(total_q);
    end else if (!built_q) begin
      rsp_d.status = sdc_pkg::StNotBuilt;
    end else if (req_i.query_value == 14'd0) begin
      rsp_d.status = sdc_pkg::StZero;
    end else if (32'(req_i.query_value) >= 32'(blim_q)) begin
      rsp_d.status = sdc_pkg::StRange;
    end else begin
      rsp_d.divisor_count = res_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rsp_load) rsp_o <= rsp_d;
  end

  always_comb begin
    sts_o = '0;
    sts_o.clr_last   = (clr_q == WW'(Words - 1));
    sts_o.sieve_over = ii > (2*LW)'(lim_q);
    sts_o.i_marked   = bits_rd_q[bitsel_q];
    sts_o.mark_over  = j_q > lim_q || {1'b0, j_q} >= (LW + 1)'(LimitMax);
    sts_o.rec_over   = i_q >= lim_q;
    sts_o.q_over     = (k_q >= total_q) || ({2'b0, p_q} > 16'(n_q)) || (p_q < 14'd2);
    sts_o.div_done   = dcnt_q == 4'd14;
    sts_o.div_exact  = rem_q == 14'd0;
    sts_o.built      = built_q;
  end
endmodule
`default_nettype wire

// ===== rtl/sdc_ctrl.sv =====
// Controller state machine sequencing build and query on the datapath.
// Depends on sdc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire sdc_pkg::req_t req_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output sdc_pkg::cmd_t      cmd_o,
  input  wire sdc_pkg::sts_t sts_i
);
  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SClr   = 4'd1;
  localparam logic [3:0] SSChk  = 4'd2;
  localparam logic [3:0] SSUse  = 4'd3;
  localparam logic [3:0] SMark  = 4'd4;
  localparam logic [3:0] SRec   = 4'd5;
  localparam logic [3:0] SQRd   = 4'd6;
  localparam logic [3:0] SQFet  = 4'd7;
  localparam logic [3:0] SQTst  = 4'd8;
  localparam logic [3:0] SDiv   = 4'd9;
  localparam logic [3:0] SDivE  = 4'd10;
  localparam logic [3:0] SResp  = 4'd11;
  localparam logic [3:0] SOut   = 4'd12;
  localparam logic [3:0] SSIni  = 4'd13;
  localparam logic [3:0] SRecW  = 4'd14;
  localparam logic [3:0] SDivR  = 4'd15;

  logic [3:0] state_q, state_d;
  logic       rmw_q, rmw_d;
  sdc_pkg::req_t req_q;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) req_q <= req_i;
  end

  always_comb begin
    state_d = state_q;
    rmw_d   = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          if (req_i.req_type == sdc_pkg::ReqBuild) begin
            cmd_o.start_build = 1'b1;
            state_d = SClr;
          end else begin
            cmd_o.q_init = 1'b1;
            state_d = SQRd;
          end
        end
      end
      SClr: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = SSIni;
      end
      SSIni: begin
        cmd_o.sieve_init = 1'b1;
        state_d = SSChk;
      end
      SSChk: begin
        if (sts_i.sieve_over) begin
          cmd_o.rec_init = 1'b1;
          state_d = SRec;
        end else begin
          cmd_o.sieve_chk = 1'b1;
          state_d = SSUse;
        end
      end
      SSUse: begin
        if (sts_i.i_marked) begin
          cmd_o.sieve_next = 1'b1;
          state_d = SSChk;
        end else begin
          cmd_o.mark_init = 1'b1;
          state_d = SMark;
        end
      end
      SMark: begin
        // Read cycle then write cycle for each multiple.
        rmw_d = !rmw_q;
        if (!rmw_q && sts_i.mark_over) begin
          cmd_o.sieve_next = 1'b1;
          rmw_d = 1'b0;
          state_d = SSChk;
        end else begin
          cmd_o.mark_step = 1'b1;
        end
      end
      SRec: begin
        rmw_d = !rmw_q;
        if (!rmw_q && sts_i.rec_over) begin
          cmd_o.build_done = 1'b1;
          rmw_d = 1'b0;
          state_d = SRecW;
        end else begin
          cmd_o.rec_step = 1'b1;
        end
      end
      SRecW: begin
        cmd_o.rsp_load = 1'b1;
        state_d = SOut;
      end
      SQRd: begin
        state_d = (req_q.query_value == 14'd0 || !sts_i.built) ? SResp : SQFet;
      end
      SQFet: begin
        cmd_o.q_fetch = 1'b1;
        state_d = SQTst;
      end
      SQTst: begin
        if (sts_i.q_over) begin
          state_d = SResp;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = SDiv;
        end
      end
      SDiv: begin
        if (sts_i.div_done) begin
          state_d = SDivE;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      SDivE: begin
        // An exact division repeats with the same prime on the new quotient.
        if (sts_i.div_exact) begin
          cmd_o.div_take = 1'b1;
          cmd_o.div_start = 1'b0;
          state_d = SDivR;
        end else begin
          cmd_o.q_next = 1'b1;
          state_d = SQRd;
        end
      end
      SDivR: begin
        cmd_o.div_start = 1'b1;
        state_d = SDiv;
      end
      SResp: begin
        cmd_o.rsp_load = 1'b1;
        state_d = SOut;
      end
      SOut: begin
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      rmw_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rmw_q   <= rmw_d;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/sieve_divisor_count.sv =====
// Top level of the sieve divisor count block: APB register, controller, datapath.
// Depends on sdc_pkg, sdc_ctrl and sdc_datapath.
//
// Usage: one request item enters on in_valid_i/in_ready_o as a req_t; one
// response item leaves on out_valid_o/out_ready_i as a rsp_t. The block works
// on one item at a time. A build clears the bit table one word a cycle, then
// marks each multiple of a sieve prime with a read and a write of its word,
// and reads each odd candidate before recording it if prime. A query walks
// the prime table; each prime tried is fetched and tested, and the value is
// divided by it (14 quotient bits at one a cycle) again while it divides exactly.
// The response is held in an output register until taken; while the receiver
// stalls no new item is accepted. After reset the table is not built,
// sieve_limit reads 13000 and queries report status 3 until a build finishes.
// sieve_limit lies at address 0 of the APB port.
`timescale 1ns / 1ps
`default_nettype none
module sieve_divisor_count #(
  parameter int unsigned LimitMax   = sdc_pkg::LimitMaxDefault,
  parameter int unsigned PrimeSlots = sdc_pkg::PrimeSlotsDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire sdc_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output sdc_pkg::rsp_t      out_data_o,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [1:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  logic [14:0]   limit_q;
  sdc_pkg::cmd_t cmd;
  sdc_pkg::sts_t sts;
  sdc_pkg::req_t req_q;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {17'd0, limit_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= sdc_pkg::LimitReset;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      limit_q <= pwdata[14:0];
    end
  end

  // Request held for the whole operation.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) req_q <= in_data_i;
  end

  sdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_i      (in_valid_i && in_ready_o ? in_data_i : req_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  sdc_datapath #(
    .LimitMax  (LimitMax),
    .PrimeSlots(PrimeSlots)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .limit_i(limit_q),
    .req_i  (in_valid_i && in_ready_o ? in_data_i : req_q),
    .rsp_o  (out_data_o)
  );
endmodule
`default_nettype wire

// ===== rtl/sdc_checker.sv =====
// Port checker for the sieve divisor count block, bound to the top level.
// Depends on sdc_pkg and sieve_divisor_count_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "sieve_divisor_count_macros.svh"
module sdc_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire sdc_pkg::rsp_t out_data_o
);
  // One item at a time: no intake while a response is pending.
  `SDC_ASSERT_IMPL(no_intake_busy, clk_i, rst_ni, out_valid_o, !in_ready_o)
  // A stalled response holds its value.
  `SDC_ASSERT_NEXT(rsp_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_data_o))
  // Accepting an item makes the block busy.
  `SDC_ASSERT_NEXT(busy_after, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // An error response carries no divisor count.
  `SDC_ASSERT_IMPL(err_zero, clk_i, rst_ni, out_valid_o && out_data_o.status != sdc_pkg::StOk,
    out_data_o.divisor_count == 8'd0)
endmodule
bind sieve_divisor_count sdc_checker u_chk (.*);
`default_nettype wire
